FILE: src/dce_pkg.sv
// ----------------------------------------------------------------------------
// Downscale capture engine package
// Shared request/result types, codes, defaults and divider interface.
// ----------------------------------------------------------------------------
package dce_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] pixel_rgb;
    } in_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pixel_value;
        logic        pixel_valid;
        logic [23:0] write_offset;
        logic [11:0] fetch_x;
        logic [11:0] fetch_y;
        logic        frame_end;
        logic [4:0]  frames_done;
        logic        capture_active;
    } out_res_t;

    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_FINISHED   = 3'd1;
    localparam logic [2:0] STS_NO_SOURCE  = 3'd2;
    localparam logic [2:0] STS_BAD_SIZE   = 3'd3;
    localparam logic [2:0] STS_TOO_LARGE  = 3'd4;
    localparam logic [2:0] STS_NO_ROOM    = 3'd5;
    localparam logic [2:0] STS_NOT_ACTIVE = 3'd6;

    localparam logic [2:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_OUT_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_OUT_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_FORMAT      = 3'd4;
    localparam logic [2:0] CFG_FRAME_LIMIT = 3'd5;
    localparam logic [2:0] CFG_CAPACITY    = 3'd6;

    localparam logic [11:0] RST_SRC_WIDTH  = 12'd640;
    localparam logic [11:0] RST_SRC_HEIGHT = 12'd480;
    localparam logic [23:0] RST_CAPACITY   = 24'd65536;

    localparam logic [11:0] SHOT_W_DEF = 12'd96;
    localparam logic [11:0] SHOT_H_DEF = 12'd54;
    localparam logic [11:0] REC_W_DEF  = 12'd64;
    localparam logic [11:0] REC_H_DEF  = 12'd36;
    localparam logic [7:0]  REC_LIM_DEF = 8'd8;
    localparam logic [23:0] SHOT_MAX_BYTES = 24'h00FFFF;

    localparam logic [14:0] LUMA_R = 15'd30;
    localparam logic [14:0] LUMA_G = 15'd59;
    localparam logic [14:0] LUMA_B = 15'd11;
    // floor(x/100) == (x*5243)>>19 for all x <= 25500
    localparam logic [27:0] LUMA_RECIP = 28'd5243;
    localparam int          LUMA_SHIFT = 19;

    localparam int DIV_W     = 24;
    localparam int DIV_STEPS = 2;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIZE,
        S_ROOM,
        S_FITS,
        S_XLOAD,
        S_XWAIT,
        S_YWAIT,
        S_RESP
    } fsm_t;

endpackage

FILE: src/dce_divider.sv
// ----------------------------------------------------------------------------
// Downscale capture engine divider
// Unsigned restoring divider, two quotient bits per cycle, one-cycle done.
// ----------------------------------------------------------------------------
module dce_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  dce_pkg::div_req_t   req,
    output dce_pkg::div_rsp_t   rsp
);

    localparam int W      = dce_pkg::DIV_W;
    localparam int CYCLES = dce_pkg::DIV_W / dce_pkg::DIV_STEPS;
    localparam int CNT_W  = $clog2(CYCLES + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       rem_t;
    logic [W-1:0]     quo_t;

    always_comb begin
        rem_t = rem_reg;
        quo_t = quo_reg;
        for (int i = 0; i < dce_pkg::DIV_STEPS; i++) begin
            rem_t = {rem_t[W-1:0], quo_t[W-1]};
            quo_t = {quo_t[W-2:0], 1'b0};
            if (rem_t >= {1'b0, dvs_reg}) begin
                rem_t    = rem_t - {1'b0, dvs_reg};
                quo_t[0] = 1'b1;
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(CYCLES);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = rem_t;
            quo_next = quo_t;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: src/downscale_capture_engine.sv
// ----------------------------------------------------------------------------
// Downscale capture engine
// Nearest-neighbor frame capture: size checks at start, RGB565/luma8
// conversion, store offsets and rounded source coordinates per pixel.
// ----------------------------------------------------------------------------
// Pixel request: two passes of the shared divider. A start request uses the
// divider only for a recording that reaches the frame-fit division.
// One request at a time; s_ready is high only when idle, while a result may
// still wait in the output register.
// Reset (synchronous, aresetn low): config and capture state to defaults, capture idle.
module downscale_capture_engine #(
    parameter int HEADER_BYTES    = 32,
    parameter int FRAME_COUNT_MAX = 24,
    parameter int MAX_OUT_SIDE    = 255,
    parameter int COORD_BITS      = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dce_pkg::in_req_t   s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output dce_pkg::out_res_t  m_res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_addr,
    input  logic [23:0]        cfg_data
);

    localparam int W = dce_pkg::DIV_W;
    localparam logic [23:0] HDR      = 24'(HEADER_BYTES);
    localparam logic [4:0]  LIM_MAX  = 5'(FRAME_COUNT_MAX);
    localparam logic [11:0] SIDE_MAX = 12'(MAX_OUT_SIDE);
    localparam logic [11:0] COORD_MASK =
        (COORD_BITS >= 12) ? 12'hFFF : 12'((1 << COORD_BITS) - 1);

    function automatic logic [15:0] to565(input logic [23:0] p);
        return {p[23:19], p[15:10], p[7:3]};
    endfunction

    function automatic logic [14:0] luma_sum(input logic [23:0] p);
        return 15'(p[23:16]) * dce_pkg::LUMA_R + 15'(p[15:8]) * dce_pkg::LUMA_G
             + 15'(p[7:0]) * dce_pkg::LUMA_B;
    endfunction

    function automatic logic [11:0] clamp_coord(input logic [W-1:0] q,
                                                input logic [11:0] src);
        logic [11:0] c;
        if (src == 12'd0) begin
            c = 12'd0;
        end else if (q >= W'(src)) begin
            c = src - 12'd1;
        end else begin
            c = q[11:0];
        end
        return c & COORD_MASK;
    endfunction

    // configuration
    logic [11:0] src_w_reg, src_h_reg, out_w_reg, out_h_reg;
    logic        fmt_reg;
    logic [7:0]  flim_reg;
    logic [23:0] cap_reg;

    // capture state
    dce_pkg::fsm_t state_reg, state_next;
    logic        active_reg, active_next;
    logic        rec_reg, rec_next;
    logic [7:0]  eff_w_reg, eff_w_next, eff_h_reg, eff_h_next;
    logic [4:0]  eff_lim_reg, eff_lim_next;
    logic [7:0]  column_reg, column_next, row_reg, row_next;
    logic [4:0]  frame_reg, frame_next;
    logic [23:0] wpos_reg, wpos_next;
    logic [11:0] next_x_reg, next_x_next, next_y_reg, next_y_next;

    // per-request work
    logic [7:0]  st_w_reg, st_w_next, st_h_reg, st_h_next;
    logic [4:0]  st_lim_reg, st_lim_next;
    logic [2:0]  wk_status_reg, wk_status_next;
    logic        wk_valid_reg, wk_valid_next;
    logic        wk_luma_reg, wk_luma_next;
    logic        wk_fend_reg, wk_fend_next;
    logic [15:0] wk_v565_reg, wk_v565_next;
    logic [14:0] wk_lsum_reg, wk_lsum_next;
    logic [23:0] wk_off_reg, wk_off_next;

    logic                 m_valid_reg, m_valid_next;
    dce_pkg::out_res_t    m_res_reg, m_res_next;

    dce_pkg::div_req_t    div_req;
    dce_pkg::div_rsp_t    div_rsp;

    logic [11:0] w_sel, h_sel, w_clamp, h_clamp;
    logic [7:0]  lim8;
    logic [4:0]  lim5;
    logic [15:0] fb;
    logic [23:0] need;
    logic [7:0]  mul_a;
    logic [11:0] mul_b;
    logic [19:0] mul_p;
    logic [7:0]  near_n;
    logic [7:0]  col_inc, row_inc;
    logic [4:0]  frame_inc;
    logic [27:0] luma_prod;
    logic [11:0] coord_src;
    logic [11:0] coord;
    logic [4:0]  fit_lim;
    logic        commit;
    logic [4:0]  commit_lim;

    dce_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // start sizing
    assign w_sel   = (out_w_reg != 12'd0) ? out_w_reg
                   : (fmt_reg ? dce_pkg::REC_W_DEF : dce_pkg::SHOT_W_DEF);
    assign h_sel   = (out_h_reg != 12'd0) ? out_h_reg
                   : (fmt_reg ? dce_pkg::REC_H_DEF : dce_pkg::SHOT_H_DEF);
    assign w_clamp = (w_sel > src_w_reg) ? src_w_reg : w_sel;
    assign h_clamp = (h_sel > src_h_reg) ? src_h_reg : h_sel;
    assign lim8    = (flim_reg != 8'd0) ? flim_reg : dce_pkg::REC_LIM_DEF;
    assign lim5    = (lim8 > 8'(LIM_MAX)) ? LIM_MAX : lim8[4:0];
    assign fb      = st_w_reg * st_h_reg;
    assign need    = 24'({fb, 1'b0}) + HDR;
    assign fit_lim = (div_rsp.quotient < W'(st_lim_reg)) ? div_rsp.quotient[4:0]
                                                          : st_lim_reg;

    // coordinate sampling: x in XLOAD, y when the x pass completes
    assign mul_a     = (state_reg == dce_pkg::S_XLOAD) ? column_reg : row_reg;
    assign mul_b     = (state_reg == dce_pkg::S_XLOAD) ? src_w_reg : src_h_reg;
    assign near_n    = (state_reg == dce_pkg::S_XLOAD) ? eff_w_reg : eff_h_reg;
    assign mul_p     = mul_a * mul_b;
    assign coord_src = (state_reg == dce_pkg::S_XWAIT) ? src_w_reg : src_h_reg;
    assign coord     = clamp_coord(div_rsp.quotient, coord_src);

    assign col_inc   = column_reg + 8'd1;
    assign row_inc   = row_reg + 8'd1;
    assign frame_inc = frame_reg + 5'd1;
    assign luma_prod = 28'(wk_lsum_reg) * dce_pkg::LUMA_RECIP;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = W'(mul_p) + W'(near_n >> 1);
        div_req.divisor  = W'(near_n);
        if (state_reg == dce_pkg::S_ROOM) begin
            div_req.dividend = cap_reg - HDR;
            div_req.divisor  = W'(fb);
        end
        if (state_reg == dce_pkg::S_XLOAD) begin
            div_req.start = 1'b1;
        end
        if (state_reg == dce_pkg::S_XWAIT && div_rsp.done) begin
            div_req.start = 1'b1;
        end
        if (state_reg == dce_pkg::S_ROOM && fmt_reg
            && !(HDR + 24'(fb) > cap_reg)) begin
            div_req.start = 1'b1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        rec_next       = rec_reg;
        eff_w_next     = eff_w_reg;
        eff_h_next     = eff_h_reg;
        eff_lim_next   = eff_lim_reg;
        column_next    = column_reg;
        row_next       = row_reg;
        frame_next     = frame_reg;
        wpos_next      = wpos_reg;
        next_x_next    = next_x_reg;
        next_y_next    = next_y_reg;
        st_w_next      = st_w_reg;
        st_h_next      = st_h_reg;
        st_lim_next    = st_lim_reg;
        wk_status_next = wk_status_reg;
        wk_valid_next  = wk_valid_reg;
        wk_luma_next   = wk_luma_reg;
        wk_fend_next   = wk_fend_reg;
        wk_v565_next   = wk_v565_reg;
        wk_lsum_next   = wk_lsum_reg;
        wk_off_next    = wk_off_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_res_next     = m_res_reg;
        commit         = 1'b0;
        commit_lim     = 5'd1;

        unique case (state_reg)
            dce_pkg::S_IDLE: begin
                if (s_valid) begin
                    wk_status_next = dce_pkg::STS_OK;
                    wk_valid_next  = 1'b0;
                    wk_fend_next   = 1'b0;
                    wk_off_next    = '0;
                    wk_luma_next   = rec_reg;
                    wk_v565_next   = to565(s_req.pixel_rgb);
                    wk_lsum_next   = luma_sum(s_req.pixel_rgb);
                    state_next     = dce_pkg::S_RESP;
                    unique case (s_req.mode)
                        dce_pkg::MODE_START: begin
                            state_next = dce_pkg::S_SIZE;
                        end
                        dce_pkg::MODE_STOP: begin
                            if (active_reg && rec_reg) begin
                                active_next = 1'b0;
                            end else begin
                                wk_status_next = dce_pkg::STS_NOT_ACTIVE;
                            end
                        end
                        dce_pkg::MODE_PIXEL: begin
                            if (!active_reg) begin
                                wk_status_next = dce_pkg::STS_NOT_ACTIVE;
                            end else begin
                                wk_valid_next = 1'b1;
                                wk_off_next   = wpos_reg;
                                wpos_next     = wpos_reg + (rec_reg ? 24'd1 : 24'd2);
                                state_next    = dce_pkg::S_XLOAD;
                                if (col_inc >= eff_w_reg) begin
                                    column_next = '0;
                                    if (row_inc >= eff_h_reg) begin
                                        row_next     = '0;
                                        wk_fend_next = 1'b1;
                                        frame_next   = frame_inc;
                                        if (frame_inc >= eff_lim_reg) begin
                                            active_next    = 1'b0;
                                            wk_status_next = dce_pkg::STS_FINISHED;
                                        end
                                    end else begin
                                        row_next = row_inc;
                                    end
                                end else begin
                                    column_next = col_inc;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dce_pkg::S_SIZE: begin
                if (src_w_reg == 12'd0 || src_h_reg == 12'd0) begin
                    wk_status_next = dce_pkg::STS_NO_SOURCE;
                    state_next     = dce_pkg::S_RESP;
                end else if (w_clamp == 12'd0 || h_clamp == 12'd0
                             || w_clamp > SIDE_MAX || h_clamp > SIDE_MAX) begin
                    wk_status_next = dce_pkg::STS_BAD_SIZE;
                    state_next     = dce_pkg::S_RESP;
                end else begin
                    st_w_next   = w_clamp[7:0];
                    st_h_next   = h_clamp[7:0];
                    st_lim_next = lim5;
                    state_next  = dce_pkg::S_ROOM;
                end
            end
            dce_pkg::S_ROOM: begin
                if (!fmt_reg) begin
                    state_next = dce_pkg::S_RESP;
                    if (need > dce_pkg::SHOT_MAX_BYTES) begin
                        wk_status_next = dce_pkg::STS_TOO_LARGE;
                    end else if (cap_reg < need) begin
                        wk_status_next = dce_pkg::STS_NO_ROOM;
                    end else begin
                        commit     = 1'b1;
                        commit_lim = 5'd1;
                    end
                end else if (HDR + 24'(fb) > cap_reg) begin
                    wk_status_next = dce_pkg::STS_NO_ROOM;
                    state_next     = dce_pkg::S_RESP;
                end else begin
                    state_next = dce_pkg::S_FITS;
                end
            end
            dce_pkg::S_FITS: begin
                if (div_rsp.done) begin
                    state_next = dce_pkg::S_RESP;
                    if (fit_lim == 5'd0) begin
                        wk_status_next = dce_pkg::STS_NO_ROOM;
                    end else begin
                        commit     = 1'b1;
                        commit_lim = fit_lim;
                    end
                end
            end
            dce_pkg::S_XLOAD: begin
                state_next = dce_pkg::S_XWAIT;
            end
            dce_pkg::S_XWAIT: begin
                if (div_rsp.done) begin
                    next_x_next = coord;
                    state_next  = dce_pkg::S_YWAIT;
                end
            end
            dce_pkg::S_YWAIT: begin
                if (div_rsp.done) begin
                    next_y_next = coord;
                    state_next  = dce_pkg::S_RESP;
                end
            end
            dce_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_res_next.status         = wk_status_reg;
                    m_res_next.pixel_valid    = wk_valid_reg;
                    m_res_next.pixel_value    = !wk_valid_reg ? 16'd0
                        : (wk_luma_reg ? {8'd0, luma_prod[dce_pkg::LUMA_SHIFT +: 8]}
                                       : wk_v565_reg);
                    m_res_next.write_offset   = wk_off_reg;
                    m_res_next.fetch_x        = next_x_reg;
                    m_res_next.fetch_y        = next_y_reg;
                    m_res_next.frame_end      = wk_fend_reg;
                    m_res_next.frames_done    = frame_reg;
                    m_res_next.capture_active = active_reg;
                    state_next                = dce_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dce_pkg::S_IDLE;
            end
        endcase

        if (commit) begin
            active_next  = 1'b1;
            rec_next     = fmt_reg;
            eff_w_next   = st_w_reg;
            eff_h_next   = st_h_reg;
            eff_lim_next = commit_lim;
            column_next  = '0;
            row_next     = '0;
            frame_next   = '0;
            wpos_next    = HDR;
            next_x_next  = '0;
            next_y_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg   <= dce_pkg::RST_SRC_WIDTH;
            src_h_reg   <= dce_pkg::RST_SRC_HEIGHT;
            out_w_reg   <= '0;
            out_h_reg   <= '0;
            fmt_reg     <= 1'b0;
            flim_reg    <= '0;
            cap_reg     <= dce_pkg::RST_CAPACITY;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                dce_pkg::CFG_SRC_WIDTH:   src_w_reg <= cfg_data[11:0];
                dce_pkg::CFG_SRC_HEIGHT:  src_h_reg <= cfg_data[11:0];
                dce_pkg::CFG_OUT_WIDTH:   out_w_reg <= cfg_data[11:0];
                dce_pkg::CFG_OUT_HEIGHT:  out_h_reg <= cfg_data[11:0];
                dce_pkg::CFG_FORMAT:      fmt_reg   <= cfg_data[0];
                dce_pkg::CFG_FRAME_LIMIT: flim_reg  <= cfg_data[7:0];
                dce_pkg::CFG_CAPACITY:    cap_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dce_pkg::S_IDLE;
            active_reg  <= 1'b0;
            rec_reg     <= 1'b0;
            eff_w_reg   <= '0;
            eff_h_reg   <= '0;
            eff_lim_reg <= '0;
            column_reg  <= '0;
            row_reg     <= '0;
            frame_reg   <= '0;
            wpos_reg    <= '0;
            next_x_reg  <= '0;
            next_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            rec_reg     <= rec_next;
            eff_w_reg   <= eff_w_next;
            eff_h_reg   <= eff_h_next;
            eff_lim_reg <= eff_lim_next;
            column_reg  <= column_next;
            row_reg     <= row_next;
            frame_reg   <= frame_next;
            wpos_reg    <= wpos_next;
            next_x_reg  <= next_x_next;
            next_y_reg  <= next_y_next;
            m_valid_reg <= m_valid_next;
        end
        st_w_reg      <= st_w_next;
        st_h_reg      <= st_h_next;
        st_lim_reg    <= st_lim_next;
        wk_status_reg <= wk_status_next;
        wk_valid_reg  <= wk_valid_next;
        wk_luma_reg   <= wk_luma_next;
        wk_fend_reg   <= wk_fend_next;
        wk_v565_reg   <= wk_v565_next;
        wk_lsum_reg   <= wk_lsum_next;
        wk_off_reg    <= wk_off_next;
        m_res_reg     <= m_res_next;
    end

    assign s_ready   = (state_reg == dce_pkg::S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_res     = m_res_reg;
    assign cfg_ready = 1'b1;

endmodule

FILE: test/tb_downscale_capture_engine.sv
// ----------------------------------------------------------------------------
// Downscale capture engine testbench
// Sends start, pixel and stop requests and checks every result against an
// in-bench model of the engine. Covers size defaults, clamping, start
// rejections, frame limits, live source changes and random captures under
// three back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_downscale_capture_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_BYTES     = 32;
    localparam int FRAME_CAP     = 24;
    localparam int SIDE_MAX      = 255;
    localparam int COORD_W       = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    dce_pkg::in_req_t   s_req;
    logic               m_valid;
    logic               m_ready;
    dce_pkg::out_res_t  m_res;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_addr;
    logic [23:0]        cfg_data;

    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 72;
    int unsigned requests_sent = 0;
    int unsigned result_mismatches = 0;

    dce_pkg::out_res_t capture_results_due[$];

    // register copy
    logic [11:0] cfg_src_w, cfg_src_h, cfg_out_w, cfg_out_h;
    logic        cfg_fmt;
    logic [7:0]  cfg_flim;
    logic [23:0] cfg_cap;

    // capture state
    bit          cap_active, cap_rec;
    logic [7:0]  eff_w, eff_h, out_col, out_row;
    logic [4:0]  eff_lim, frames;
    logic [23:0] wr_pos;
    logic [11:0] nx, ny;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    downscale_capture_engine #(
        .HEADER_BYTES   (HDR_BYTES),
        .FRAME_COUNT_MAX(FRAME_CAP),
        .MAX_OUT_SIDE   (SIDE_MAX),
        .COORD_BITS     (COORD_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_req    (s_req),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    function automatic logic [11:0] nearest_src(int unsigned i, int unsigned n,
                                                int unsigned src);
        int unsigned s;
        if (n == 0 || src == 0) return 12'd0;
        s = (i * src + n / 2) / n;
        if (s >= src) s = src - 1;
        return 12'(s);
    endfunction

    function automatic logic [2:0] start_capture();
        int unsigned w, h, need, fb, lim, fits;
        bit rec;
        rec = cfg_fmt;
        if (cfg_src_w == 0 || cfg_src_h == 0) return dce_pkg::STS_NO_SOURCE;
        w = (cfg_out_w != 0) ? cfg_out_w
                             : (rec ? dce_pkg::REC_W_DEF : dce_pkg::SHOT_W_DEF);
        h = (cfg_out_h != 0) ? cfg_out_h
                             : (rec ? dce_pkg::REC_H_DEF : dce_pkg::SHOT_H_DEF);
        if (w > cfg_src_w) w = cfg_src_w;
        if (h > cfg_src_h) h = cfg_src_h;
        if (w == 0 || h == 0 || w > SIDE_MAX || h > SIDE_MAX)
            return dce_pkg::STS_BAD_SIZE;
        if (!rec) begin
            need = w * h * 2 + HDR_BYTES;
            if (need > dce_pkg::SHOT_MAX_BYTES) return dce_pkg::STS_TOO_LARGE;
            if (cfg_cap < need) return dce_pkg::STS_NO_ROOM;
            lim = 1;
        end else begin
            lim = (cfg_flim != 0) ? cfg_flim : dce_pkg::REC_LIM_DEF;
            if (lim > FRAME_CAP) lim = FRAME_CAP;
            fb = w * h;
            if (HDR_BYTES + fb > cfg_cap) return dce_pkg::STS_NO_ROOM;
            fits = (cfg_cap - HDR_BYTES) / fb;
            if (lim > fits) lim = fits;
            if (lim == 0) return dce_pkg::STS_NO_ROOM;
        end
        cap_active = 1'b1;
        cap_rec    = rec;
        eff_w      = 8'(w);
        eff_h      = 8'(h);
        eff_lim    = 5'(lim);
        out_col    = '0;
        out_row    = '0;
        frames     = '0;
        wr_pos     = 24'(HDR_BYTES);
        nx         = nearest_src(0, w, cfg_src_w);
        ny         = nearest_src(0, h, cfg_src_h);
        return dce_pkg::STS_OK;
    endfunction

    function automatic dce_pkg::out_res_t next_capture_result(dce_pkg::in_req_t req);
        dce_pkg::out_res_t res;
        logic [7:0]        r8, g8, b8;
        int unsigned       luma;
        res = '0;
        r8 = req.pixel_rgb[23:16];
        g8 = req.pixel_rgb[15:8];
        b8 = req.pixel_rgb[7:0];
        case (req.mode)
            dce_pkg::MODE_START: begin
                res.status = start_capture();
            end
            dce_pkg::MODE_STOP: begin
                if (cap_active && cap_rec) cap_active = 1'b0;
                else res.status = dce_pkg::STS_NOT_ACTIVE;
            end
            dce_pkg::MODE_PIXEL: begin
                if (!cap_active) begin
                    res.status = dce_pkg::STS_NOT_ACTIVE;
                end else begin
                    res.pixel_valid  = 1'b1;
                    res.write_offset = wr_pos;
                    if (cap_rec) begin
                        luma = (r8 * 30 + g8 * 59 + b8 * 11) / 100;
                        res.pixel_value = 16'(luma);
                        wr_pos = wr_pos + 24'd1;
                    end else begin
                        res.pixel_value = {r8[7:3], g8[7:2], b8[7:3]};
                        wr_pos = wr_pos + 24'd2;
                    end
                    out_col = out_col + 8'd1;
                    if (out_col >= eff_w) begin
                        out_col = '0;
                        out_row = out_row + 8'd1;
                        if (out_row >= eff_h) begin
                            out_row = '0;
                            res.frame_end = 1'b1;
                            frames = frames + 5'd1;
                            if (frames >= eff_lim) begin
                                cap_active = 1'b0;
                                res.status = dce_pkg::STS_FINISHED;
                            end
                        end
                    end
                    nx = nearest_src(out_col, eff_w, cfg_src_w);
                    ny = nearest_src(out_row, eff_h, cfg_src_h);
                end
            end
            default: ;
        endcase
        res.fetch_x        = nx;
        res.fetch_y        = ny;
        res.frames_done    = frames;
        res.capture_active = cap_active;
        return res;
    endfunction

    task automatic send_request(logic [1:0] mode, logic [23:0] rgb);
        int unsigned      gap;
        dce_pkg::in_req_t req;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        req.mode      = mode;
        req.pixel_rgb = rgb;
        s_valid <= 1'b1;
        s_req   <= req;
        do @(posedge aclk); while (!s_ready);
        capture_results_due.push_back(next_capture_result(req));
        requests_sent++;
    endtask

    task automatic release_request();
        s_valid <= 1'b0;
    endtask

    task automatic write_register(logic [2:0] addr, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (addr)
            dce_pkg::CFG_SRC_WIDTH:   cfg_src_w = data[11:0];
            dce_pkg::CFG_SRC_HEIGHT:  cfg_src_h = data[11:0];
            dce_pkg::CFG_OUT_WIDTH:   cfg_out_w = data[11:0];
            dce_pkg::CFG_OUT_HEIGHT:  cfg_out_h = data[11:0];
            dce_pkg::CFG_FORMAT:      cfg_fmt   = data[0];
            dce_pkg::CFG_FRAME_LIMIT: cfg_flim  = data[7:0];
            dce_pkg::CFG_CAPACITY:    cfg_cap   = data;
            default: ;
        endcase
    endtask

    task automatic release_register();
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        release_request();
        while (capture_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic setup_capture(logic [11:0] sw, logic [11:0] sh, logic [11:0] ow,
                                 logic [11:0] oh, logic fmt, logic [7:0] flim,
                                 logic [23:0] cap);
        drain_and_settle();
        write_register(dce_pkg::CFG_SRC_WIDTH, {12'd0, sw});
        write_register(dce_pkg::CFG_SRC_HEIGHT, {12'd0, sh});
        write_register(dce_pkg::CFG_OUT_WIDTH, {12'd0, ow});
        write_register(dce_pkg::CFG_OUT_HEIGHT, {12'd0, oh});
        write_register(dce_pkg::CFG_FORMAT, {23'd0, fmt});
        write_register(dce_pkg::CFG_FRAME_LIMIT, {16'd0, flim});
        write_register(dce_pkg::CFG_CAPACITY, cap);
        release_register();
    endtask

    function automatic logic [11:0] rand_src_side();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) return 12'd0;
        if (pick < 10) return 12'hFFF;
        if (pick < 25) return 12'($urandom_range(1, 6));
        return 12'($urandom_range(8, 800));
    endfunction

    function automatic logic [11:0] rand_out_side();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) return 12'd0;
        if (pick < 15) return 12'($urandom_range(256, 4095));
        if (pick < 20) return 12'($urandom_range(9, 255));
        return 12'($urandom_range(1, 4));
    endfunction

    task automatic randomize_setup();
        int unsigned pick;
        logic [7:0]  flim;
        logic [23:0] cap;
        pick = $urandom_range(99);
        if (pick < 10) flim = 8'd0;
        else if (pick < 20) flim = 8'd255;
        else if (pick < 30) flim = 8'($urandom_range(25, 254));
        else flim = 8'($urandom_range(1, 6));
        pick = $urandom_range(99);
        if (pick < 10) cap = 24'($urandom_range(0, 64));
        else if (pick < 15) cap = 24'hFFFFFF;
        else if (pick < 25) cap = 24'($urandom_range(32, 300));
        else cap = 24'($urandom_range(1000, 200000));
        setup_capture(rand_src_side(), rand_src_side(), rand_out_side(), rand_out_side(),
                      1'($urandom_range(1)), flim, cap);
    endtask

    task automatic check_capture_result(dce_pkg::out_res_t act);
        dce_pkg::out_res_t exp;
        if (capture_results_due.size() == 0) begin
            result_mismatches++;
            if (result_mismatches <= MAX_REPORTS)
                $display("%0t: result with nothing outstanding: %p", $realtime, act);
            return;
        end
        exp = capture_results_due.pop_front();
        if (act.status !== exp.status || act.pixel_value !== exp.pixel_value ||
            act.pixel_valid !== exp.pixel_valid || act.write_offset !== exp.write_offset ||
            act.fetch_x !== exp.fetch_x || act.fetch_y !== exp.fetch_y ||
            act.frame_end !== exp.frame_end || act.frames_done !== exp.frames_done ||
            act.capture_active !== exp.capture_active) begin
            result_mismatches++;
            if (result_mismatches <= MAX_REPORTS) begin
                $display("%0t: exp sts=%0d val=%h vld=%b off=%h x=%0d y=%0d fe=%b fd=%0d act=%b",
                         $realtime, exp.status, exp.pixel_value, exp.pixel_valid,
                         exp.write_offset, exp.fetch_x, exp.fetch_y, exp.frame_end,
                         exp.frames_done, exp.capture_active);
                $display("%0t: got sts=%0d val=%h vld=%b off=%h x=%0d y=%0d fe=%b fd=%0d act=%b",
                         $realtime, act.status, act.pixel_value, act.pixel_valid,
                         act.write_offset, act.fetch_x, act.fetch_y, act.frame_end,
                         act.frames_done, act.capture_active);
            end
        end
    endtask

    task automatic test_idle_requests();
        send_request(dce_pkg::MODE_PIXEL, 24'hFFFFFF);
        send_request(dce_pkg::MODE_STOP, 24'h000000);
        send_request(MODE_UNUSED, 24'h5A5A5A);
    endtask

    task automatic test_shot_capture();
        setup_capture(12'd640, 12'd480, 12'd2, 12'd2, 1'b0, 8'd0, dce_pkg::RST_CAPACITY);
        send_request(dce_pkg::MODE_START, 24'h000000);
        send_request(dce_pkg::MODE_PIXEL, 24'h000000);
        send_request(dce_pkg::MODE_PIXEL, 24'hFFFFFF);
        send_request(dce_pkg::MODE_PIXEL, 24'hF8FC00);
        send_request(dce_pkg::MODE_PIXEL, 24'h0703FF);
        send_request(dce_pkg::MODE_START, 24'h123456);
        // stop has no effect on a shot
        send_request(dce_pkg::MODE_STOP, 24'h000000);
    endtask

    task automatic test_start_checks();
        // rejected starts leave the running shot alone
        setup_capture(12'd0, 12'd480, 12'd3, 12'd2, 1'b0, 8'd0, dce_pkg::RST_CAPACITY);
        send_request(dce_pkg::MODE_START, 24'h0);
        send_request(dce_pkg::MODE_PIXEL, 24'hA5A5A5);
        setup_capture(12'd640, 12'd0, 12'd3, 12'd2, 1'b0, 8'd0, dce_pkg::RST_CAPACITY);
        send_request(dce_pkg::MODE_START, 24'h0);
        setup_capture(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 8'd0, dce_pkg::RST_CAPACITY);
        send_request(dce_pkg::MODE_START, 24'h0);
        setup_capture(12'hFFF, 12'hFFF, 12'd255, 12'd255, 1'b0, 8'd0, 24'hFFFFFF);
        send_request(dce_pkg::MODE_START, 24'h0);
        setup_capture(12'd640, 12'd480, 12'd100, 12'd100, 1'b0, 8'd0, 24'd20031);
        send_request(dce_pkg::MODE_START, 24'h0);
        setup_capture(12'd640, 12'd480, 12'd100, 12'd100, 1'b0, 8'd0, 24'd20032);
        send_request(dce_pkg::MODE_START, 24'h0);
        setup_capture(12'd5, 12'd480, 12'd200, 12'd3, 1'b0, 8'd0, dce_pkg::RST_CAPACITY);
        send_request(dce_pkg::MODE_START, 24'h0);
        send_request(dce_pkg::MODE_PIXEL, 24'h3C3C3C);
        setup_capture(12'd640, 12'd480, 12'd0, 12'd0, 1'b1, 8'd0, 24'd0);
        send_request(dce_pkg::MODE_START, 24'h0);
        setup_capture(12'd640, 12'd480, 12'd0, 12'd0, 1'b1, 8'd255, 24'hFFFFFF);
        send_request(dce_pkg::MODE_START, 24'h0);
        send_request(dce_pkg::MODE_PIXEL, 24'hFFFFFF);
        setup_capture(12'd640, 12'd480, 12'd0, 12'd0, 1'b1, 8'd0, 24'hFFFFFF);
        send_request(dce_pkg::MODE_START, 24'h0);
    endtask

    task automatic test_recording_limits();
        // store holds three 2x1 frames
        setup_capture(12'd640, 12'd480, 12'd2, 12'd1, 1'b1, 8'd10, 24'd38);
        send_request(dce_pkg::MODE_START, 24'h0);
        repeat (6) send_request(dce_pkg::MODE_PIXEL, 24'($urandom()));
        send_request(dce_pkg::MODE_PIXEL, 24'h808080);
        setup_capture(12'd640, 12'd480, 12'd2, 12'd2, 1'b1, 8'd1, dce_pkg::RST_CAPACITY);
        send_request(dce_pkg::MODE_START, 24'h0);
        send_request(dce_pkg::MODE_PIXEL, 24'hFFFFFF);
        send_request(dce_pkg::MODE_STOP, 24'h0);
        send_request(dce_pkg::MODE_STOP, 24'h0);
    endtask

    task automatic test_live_source();
        setup_capture(12'd640, 12'd480, 12'd4, 12'd4, 1'b1, 8'd0, dce_pkg::RST_CAPACITY);
        send_request(dce_pkg::MODE_START, 24'h0);
        send_request(dce_pkg::MODE_PIXEL, 24'h102030);
        drain_and_settle();
        write_register(dce_pkg::CFG_SRC_WIDTH, 24'd0);
        release_register();
        send_request(dce_pkg::MODE_PIXEL, 24'h405060);
        drain_and_settle();
        write_register(dce_pkg::CFG_SRC_WIDTH, 24'hFFF);
        write_register(dce_pkg::CFG_SRC_HEIGHT, 24'd1);
        release_register();
        send_request(dce_pkg::MODE_PIXEL, 24'h708090);
        send_request(dce_pkg::MODE_PIXEL, 24'hA0B0C0);
    endtask

    task automatic test_random_captures(int unsigned n_items);
        int unsigned stop_at, budget, k, pick;
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at) begin
            randomize_setup();
            send_request(dce_pkg::MODE_START, 24'($urandom()));
            budget = $urandom_range(20, 150);
            k = 0;
            while (cap_active && k < budget && requests_sent < stop_at) begin
                pick = $urandom_range(999);
                if (pick < 15) begin
                    send_request(dce_pkg::MODE_STOP, 24'($urandom()));
                end else if (pick < 25) begin
                    send_request(dce_pkg::MODE_START, 24'($urandom()));
                end else if (pick < 30) begin
                    send_request(MODE_UNUSED, 24'($urandom()));
                end else if (pick < 36) begin
                    drain_and_settle();
                    if ($urandom_range(1))
                        write_register(dce_pkg::CFG_SRC_WIDTH, {12'd0, rand_src_side()});
                    else
                        write_register(dce_pkg::CFG_SRC_HEIGHT, {12'd0, rand_src_side()});
                    release_register();
                end else begin
                    send_request(dce_pkg::MODE_PIXEL, 24'($urandom()));
                end
                k++;
            end
            send_request(2'($urandom_range(2)), 24'($urandom()));
        end
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_capture_result(m_res);
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_req     <= '0;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        cfg_src_w = dce_pkg::RST_SRC_WIDTH;
        cfg_src_h = dce_pkg::RST_SRC_HEIGHT;
        cfg_out_w = '0;
        cfg_out_h = '0;
        cfg_fmt   = 1'b0;
        cfg_flim  = '0;
        cfg_cap   = dce_pkg::RST_CAPACITY;
        cap_active = 1'b0;
        cap_rec    = 1'b0;
        eff_w = '0; eff_h = '0; eff_lim = '0;
        out_col = '0; out_row = '0; frames = '0;
        wr_pos = '0; nx = '0; ny = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_requests();
        test_shot_capture();
        test_start_checks();
        test_recording_limits();
        test_live_source();
        test_random_captures(400);
        send_idle_pct = 72;
        recv_idle_pct = 21;
        test_random_captures(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_captures(400);

        drain_and_settle();
        if (result_mismatches == 0 && capture_results_due.size() == 0) begin
            $display("tb_downscale_capture_engine: PASS");
        end else begin
            $display("tb_downscale_capture_engine: FAIL");
        end
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("tb_downscale_capture_engine: FAIL");
        $finish;
    end

endmodule
